// ===== src/opf_pkg.sv =====
// opf_pkg: shared codes, widths and types of the overflow policy fifo
// used by opf_ram and overflow_policy_fifo; depends on nothing
package opf_pkg;

  localparam int DataW    = 32;
  localparam int CapW     = 5;
  localparam int OccW     = 5;
  localparam int CfgIdxW  = 2;
  localparam int CfgDataW = 5;

  typedef enum logic [1:0] {
    CMD_PUSH   = 2'd0,
    CMD_POP    = 2'd1,
    CMD_PEEK   = 2'd2,
    CMD_STATUS = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    ST_OK          = 2'd0,
    ST_FULL_DROP   = 2'd1,
    ST_WOULD_BLOCK = 2'd2,
    ST_EMPTY       = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    POL_DROP_NEWEST = 2'd0,
    POL_DROP_OLDEST = 2'd1,
    POL_BLOCK       = 2'd2
  } policy_e;

  localparam logic [CfgIdxW-1:0] RegCapacity   = 2'd0;
  localparam logic [CfgIdxW-1:0] RegDropPolicy = 2'd1;

  localparam logic [CapW-1:0] CapReset    = 5'd16;
  localparam logic [1:0]      PolicyReset = POL_BLOCK;

  typedef struct packed {
    logic wr_en;
    logic rd_en;
  } ram_ctrl_t;

endpackage

// ===== src/overflow_policy_fifo.sv =====
// overflow_policy_fifo: ring-buffer fifo with a drop-newest, drop-oldest or block policy
// result: an accepted word gives its result word in the next cycle
// throughput: one word per cycle; the single result register stalls the input
// while its word is not taken, the entry store is read at most once per word
// reset: counters, pointers and fill clear, capacity 16, policy block; entries undefined
module overflow_policy_fifo import opf_pkg::*; #(
  parameter int DEPTH         = 16,
  parameter int PAYLOAD_WIDTH = 32
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  // configuration
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  // input words
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [1:0]          cmd_i,
  input  logic [DataW-1:0]    payload_i,
  input  logic [DataW-1:0]    now_time_i,
  // result words
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [1:0]          status_o,
  output logic [DataW-1:0]    out_payload_o,
  output logic [DataW-1:0]    out_stamp_o,
  output logic [DataW-1:0]    out_sequence_o,
  output logic [OccW-1:0]     occupancy_o,
  output logic [DataW-1:0]    written_total_o,
  output logic [DataW-1:0]    read_total_o,
  output logic [DataW-1:0]    dropped_total_o,
  output logic [OccW-1:0]     peak_occupancy_o
);

  // the capacity register cannot address beyond its own range
  localparam int MaxCap  = (1 << CapW) - 1;
  localparam int UseDepth = (DEPTH < MaxCap) ? DEPTH : MaxCap;
  localparam int PtrW    = $clog2(UseDepth);
  localparam int CntW    = $clog2(UseDepth + 1);
  localparam int StoreW  = (PAYLOAD_WIDTH < DataW) ? PAYLOAD_WIDTH : DataW;
  localparam int EntryW  = StoreW + 2 * DataW;

  logic [CapW-1:0]  capacity_q;
  logic [1:0]       policy_q;
  logic [PtrW-1:0]  head_q, head_d, tail_q, tail_d;
  logic [CntW-1:0]  fill_q, fill_d, peak_q, peak_d;
  logic [DataW-1:0] seq_q, seq_d, pushes_q, pushes_d, pops_q, pops_d, drops_q, drops_d;
  logic             out_valid_q, hit_q, hit_d;
  status_e          status_q, status_d;

  logic [CapW-1:0]   cap;
  logic              accept, full, empty;
  logic [PtrW-1:0]   rd_addr;
  ram_ctrl_t         ram_ctrl;
  logic [EntryW-1:0] wr_entry, rd_entry;

  function automatic logic [PtrW-1:0] adv(input logic [PtrW-1:0] p,
                                          input logic [CapW-1:0] c);
    logic [CapW:0] n;
    n = (CapW+1)'(p) + (CapW+1)'(1);
    return (n >= {1'b0, c}) ? '0 : PtrW'(n);
  endfunction

  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = !out_valid_q || out_ready_i;
  assign accept      = in_valid_i && in_ready_o;

  always_comb begin
    if (capacity_q == '0) begin
      cap = CapW'(1);
    end else if (capacity_q > CapW'(UseDepth)) begin
      cap = CapW'(UseDepth);
    end else begin
      cap = capacity_q;
    end
  end

  assign full  = CapW'(fill_q) >= cap;
  assign empty = fill_q == '0;

  always_comb begin
    logic insert;
    insert   = 1'b0;
    head_d   = head_q;
    tail_d   = tail_q;
    fill_d   = fill_q;
    seq_d    = seq_q;
    pushes_d = pushes_q;
    pops_d   = pops_q;
    drops_d  = drops_q;
    peak_d   = peak_q;
    status_d = ST_OK;
    hit_d    = 1'b0;
    rd_addr  = tail_q;
    unique case (cmd_e'(cmd_i))
      CMD_PUSH: begin
        insert = 1'b1;
        if (full) begin
          case (policy_e'(policy_q))
            POL_DROP_NEWEST: begin
              drops_d  = drops_q + DataW'(1);
              status_d = ST_FULL_DROP;
              insert   = 1'b0;
            end
            POL_DROP_OLDEST: begin
              tail_d  = adv(tail_q, cap);
              fill_d  = fill_q - CntW'(1);
              drops_d = drops_q + DataW'(1);
            end
            default: begin
              // unused policy code behaves as block
              status_d = ST_WOULD_BLOCK;
              insert   = 1'b0;
            end
          endcase
        end
        if (insert) begin
          seq_d    = seq_q + DataW'(1);
          head_d   = adv(head_q, cap);
          fill_d   = fill_d + CntW'(1);
          pushes_d = pushes_q + DataW'(1);
          if (fill_d > peak_q) begin
            peak_d = fill_d;
          end
        end
      end
      CMD_POP: begin
        if (empty) begin
          status_d = ST_EMPTY;
        end else begin
          hit_d   = 1'b1;
          tail_d  = adv(tail_q, cap);
          fill_d  = fill_q - CntW'(1);
          pops_d  = pops_q + DataW'(1);
        end
      end
      CMD_PEEK: begin
        if (empty) begin
          status_d = ST_EMPTY;
        end else begin
          hit_d   = 1'b1;
          rd_addr = (head_q == '0) ? PtrW'(cap - CapW'(1)) : head_q - PtrW'(1);
        end
      end
      CMD_STATUS: begin
      end
      default: begin
      end
    endcase
    ram_ctrl.wr_en = accept && insert;
    ram_ctrl.rd_en = accept && hit_d;
  end

  assign wr_entry = {payload_i[StoreW-1:0], now_time_i, seq_q};

  opf_ram #(
    .WIDTH (EntryW),
    .DEPTH (UseDepth)
  ) u_ram (
    .clk_i     (clk_i),
    .ctrl_i    (ram_ctrl),
    .wr_addr_i (head_q),
    .wr_data_i (wr_entry),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_entry)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      capacity_q <= CapReset;
      policy_q   <= PolicyReset;
    end else if (cfg_valid_i && cfg_ready_o) begin
      if (cfg_index_i == RegCapacity) begin
        capacity_q <= cfg_data_i[CapW-1:0];
      end else if (cfg_index_i == RegDropPolicy) begin
        policy_q <= cfg_data_i[1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q   <= '0;
      tail_q   <= '0;
      fill_q   <= '0;
      peak_q   <= '0;
      seq_q    <= '0;
      pushes_q <= '0;
      pops_q   <= '0;
      drops_q  <= '0;
    end else if (accept) begin
      head_q   <= head_d;
      tail_q   <= tail_d;
      fill_q   <= fill_d;
      peak_q   <= peak_d;
      seq_q    <= seq_d;
      pushes_q <= pushes_d;
      pops_q   <= pops_d;
      drops_q  <= drops_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      hit_q       <= 1'b0;
      status_q    <= ST_OK;
    end else if (accept) begin
      out_valid_q <= 1'b1;
      hit_q       <= hit_d;
      status_q    <= status_d;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // state registers hold the totals after the word in flight until the next word
  assign out_valid_o      = out_valid_q;
  assign status_o         = status_q;
  assign out_payload_o    = hit_q ? DataW'(rd_entry[EntryW-1 -: StoreW]) : '0;
  assign out_stamp_o      = hit_q ? rd_entry[2*DataW-1 -: DataW] : '0;
  assign out_sequence_o   = hit_q ? rd_entry[DataW-1:0] : '0;
  assign occupancy_o      = OccW'(fill_q);
  assign written_total_o  = pushes_q;
  assign read_total_o     = pops_q;
  assign dropped_total_o  = drops_q;
  assign peak_occupancy_o = OccW'(peak_q);

`ifndef SYNTH
  a_fill_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= CntW'(UseDepth))
    else $error("fill count beyond store depth");

  a_stall_blocks_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |-> !in_ready_o)
    else $error("input taken while result word is stalled");

  a_pop_decrements: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && cmd_i == CMD_POP && !empty |=> fill_q == $past(fill_q) - CntW'(1))
    else $error("pop did not remove one entry");

  a_empty_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && (cmd_i == CMD_POP || cmd_i == CMD_PEEK) && empty
      |=> status_o == ST_EMPTY && fill_q == '0 && !hit_q)
    else $error("empty read changed state or returned data");

  a_peak_covers_fill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && cmd_i == CMD_PUSH && status_d == ST_OK |=> peak_q >= fill_q)
    else $error("peak occupancy below occupancy after push");
`endif

endmodule

// ===== src/opf_ram.sv =====
// opf_ram: entry store of the fifo, one write and one registered read port
// depends on opf_pkg for the port control struct
module opf_ram import opf_pkg::*; #(
  parameter int WIDTH = 96,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  ram_ctrl_t                ctrl_i,
  input  logic [$clog2(DEPTH)-1:0] wr_addr_i,
  input  logic [WIDTH-1:0]         wr_data_i,
  input  logic [$clog2(DEPTH)-1:0] rd_addr_i,
  output logic [WIDTH-1:0]         rd_data_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (ctrl_i.wr_en) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.rd_en) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule
